// ===== design/etbb_pkg.sv =====
package etbb_pkg;

	// Vertex store geometry
	localparam int VERTEX_DEPTH = 4096;
	localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
	localparam int IDX_W        = 12;

	// Field and arithmetic widths
	localparam int POS_W  = 32;
	localparam int NRM_W  = 18;
	localparam int OFS_W  = 31;
	localparam int PROD_W = NRM_W + OFS_W + 1;
	localparam int FRAC_W = 16;
	localparam int TERM_W = PROD_W - FRAC_W;
	localparam int SUM_W  = TERM_W + 1;

	// Item commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes
	localparam int   CFG_IDX_W = 1;
	localparam logic REG_INNER = 1'b0;
	localparam logic REG_OUTER = 1'b1;

	// Triangle corner select
	localparam logic [1:0] CORNER_A = 2'd0;
	localparam logic [1:0] CORNER_B = 2'd1;
	localparam logic [1:0] CORNER_C = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic       wr_en;
		logic       capture;
		logic       fetch;
		logic [1:0] corner;
		logic       load_out;
	} etbb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_s3;
		logic out_full;
	} etbb_status_t;

endpackage

// ===== design/extruded_triangle_bounding_box_core.sv =====
// Triangle shell bounding box.
// Input channel (in_valid / in_stall): cmd = 0 loads vertex_index with a position
// and unit normal; cmd = 1 queries the box of the triangle corner_a/b/c.
// Output channel (out_valid / out_stall): one box (min_*, max_*) per query,
// none per load. The user must set offsets through cfg_we / cfg_index /
// cfg_data only while idle; the block does not enforce this. Loads never
// stall the input. A query reads its three corners from the single-port
// vertex store, one per cycle, then runs a three-stage multiply, add/saturate
// and min/max pipeline; then the result register loads and the input reopens.
// The result register is separate from the engine, so a waiting result does not
// block loads or the next query; a query finishing while the previous result is
// still stalled holds in its last state until that result transfers.
// Reset clears control and the offset registers; the vertex store is not
// cleared, and an entry read before it was loaded returns undefined data.

module extruded_triangle_bounding_box_core
	import etbb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [OFS_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [IDX_W-1:0]        vertex_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic signed [NRM_W-1:0] norm_x,
	input  logic signed [NRM_W-1:0] norm_y,
	input  logic signed [NRM_W-1:0] norm_z,
	input  logic [IDX_W-1:0]        corner_a,
	input  logic [IDX_W-1:0]        corner_b,
	input  logic [IDX_W-1:0]        corner_c,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] min_x,
	output logic signed [POS_W-1:0] min_y,
	output logic signed [POS_W-1:0] min_z,
	output logic signed [POS_W-1:0] max_x,
	output logic signed [POS_W-1:0] max_y,
	output logic signed [POS_W-1:0] max_z
);

	etbb_cmd_t    ctl;
	etbb_status_t status;

	etbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	etbb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.vertex_index (vertex_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.min_x        (min_x),
		.min_y        (min_y),
		.min_z        (min_z),
		.max_x        (max_x),
		.max_y        (max_y),
		.max_z        (max_z)
	);

endmodule

// ===== design/etbb_ctrl.sv =====
module etbb_ctrl
	import etbb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         cmd,
	output logic         in_stall,
	input  etbb_status_t status,
	output etbb_cmd_t    ctl
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] corner_q, corner_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		corner_d     = corner_q;
		ctl.wr_en    = 1'b0;
		ctl.capture  = 1'b0;
		ctl.fetch    = 1'b0;
		ctl.corner   = corner_q;
		ctl.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_QUERY) begin
						ctl.capture = 1'b1;
						corner_d    = CORNER_A;
						state_d     = S_FETCH;
					end else begin
						ctl.wr_en = 1'b1;
					end
				end
			end
			S_FETCH: begin
				ctl.fetch = 1'b1;
				if (corner_q == CORNER_C) begin
					state_d = S_WAIT;
				end else begin
					corner_d = corner_q + 2'd1;
				end
			end
			S_WAIT: begin
				if (status.last_s3) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!status.out_full) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			corner_q <= CORNER_A;
		end else begin
			state_q  <= state_d;
			corner_q <= corner_d;
		end
	end

endmodule

// ===== design/etbb_datapath.sv =====
module etbb_datapath
	import etbb_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  etbb_cmd_t                   ctl,
	output etbb_status_t                status,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [OFS_W-1:0]            cfg_data,
	input  logic [IDX_W-1:0]            vertex_index,
	input  logic signed [POS_W-1:0]     pos_x,
	input  logic signed [POS_W-1:0]     pos_y,
	input  logic signed [POS_W-1:0]     pos_z,
	input  logic signed [NRM_W-1:0]     norm_x,
	input  logic signed [NRM_W-1:0]     norm_y,
	input  logic signed [NRM_W-1:0]     norm_z,
	input  logic [IDX_W-1:0]            corner_a,
	input  logic [IDX_W-1:0]            corner_b,
	input  logic [IDX_W-1:0]            corner_c,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [POS_W-1:0]     min_x,
	output logic signed [POS_W-1:0]     min_y,
	output logic signed [POS_W-1:0]     min_z,
	output logic signed [POS_W-1:0]     max_x,
	output logic signed [POS_W-1:0]     max_y,
	output logic signed [POS_W-1:0]     max_z
);

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// Clamp a widened sum to the signed position range
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic upper_same;
		upper_same = (v[SUM_W-1:POS_W-1] == {(SUM_W-POS_W+1){1'b0}}) ||
		             (v[SUM_W-1:POS_W-1] == {(SUM_W-POS_W+1){1'b1}});
		if (upper_same) begin
			return v[POS_W-1:0];
		end
		return v[SUM_W-1] ? POS_MIN : POS_MAX;
	endfunction

	// Configuration registers
	logic [OFS_W-1:0] inner_q, outer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			outer_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INNER: inner_q <= cfg_data;
				REG_OUTER: outer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Query corners held for the fetch sequence
	logic [IDX_W-1:0] corner_a_q, corner_b_q, corner_c_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			corner_a_q <= corner_a;
			corner_b_q <= corner_b;
			corner_c_q <= corner_c;
		end
	end

	// Store addressing
	logic [IDX_W-1:0] rd_idx;
	logic             rd_in_range, wr_in_range;

	always_comb begin
		case (ctl.corner)
			CORNER_A: rd_idx = corner_a_q;
			CORNER_B: rd_idx = corner_b_q;
			default:  rd_idx = corner_c_q;
		endcase
	end

	assign rd_in_range = ({1'b0, rd_idx} < (IDX_W+1)'(VERTEX_DEPTH));
	assign wr_in_range = ({1'b0, vertex_index} < (IDX_W+1)'(VERTEX_DEPTH));

	// Single-port vertex store, read data registered
	logic [3*POS_W-1:0] pos_mem [VERTEX_DEPTH];
	logic [3*NRM_W-1:0] nrm_mem [VERTEX_DEPTH];
	logic [3*POS_W-1:0] pos_rd_s1;
	logic [3*NRM_W-1:0] nrm_rd_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && wr_in_range) begin
			pos_mem[vertex_index[ADDR_W-1:0]] <= {pos_z, pos_y, pos_x};
			nrm_mem[vertex_index[ADDR_W-1:0]] <= {norm_z, norm_y, norm_x};
		end else if (ctl.fetch) begin
			pos_rd_s1 <= pos_mem[rd_idx[ADDR_W-1:0]];
			nrm_rd_s1 <= nrm_mem[rd_idx[ADDR_W-1:0]];
		end
	end

	// Pipeline tags
	logic vld_s1, range_s1, first_s1, last_s1;
	logic vld_s2, first_s2, last_s2;
	logic vld_s3, first_s3, last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= ctl.fetch;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		range_s1 <= rd_in_range;
		first_s1 <= (ctl.corner == CORNER_A);
		last_s1  <= (ctl.corner == CORNER_C);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
	end

	// Stage 2: offset products, one multiplier per axis and side
	logic signed [PROD_W-1:0] prod_in_s2  [3];
	logic signed [PROD_W-1:0] prod_out_s2 [3];
	logic signed [POS_W-1:0]  pos_s2      [3];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			logic signed [NRM_W-1:0] nrm;
			nrm = range_s1 ? signed'(nrm_rd_s1[a*NRM_W +: NRM_W]) : '0;
			prod_in_s2[a]  <= nrm * $signed({1'b0, inner_q});
			prod_out_s2[a] <= nrm * $signed({1'b0, outer_q});
			pos_s2[a]      <= range_s1 ? signed'(pos_rd_s1[a*POS_W +: POS_W]) : '0;
		end
	end

	// Stage 3: floor shift, add or subtract, saturate
	logic signed [POS_W-1:0] ip_s3 [3];
	logic signed [POS_W-1:0] op_s3 [3];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			logic signed [SUM_W-1:0] p_w, ti_w, to_w;
			p_w  = signed'({{(SUM_W-POS_W){pos_s2[a][POS_W-1]}}, pos_s2[a]});
			ti_w = signed'({prod_in_s2[a][PROD_W-1], prod_in_s2[a][PROD_W-1:FRAC_W]});
			to_w = signed'({prod_out_s2[a][PROD_W-1], prod_out_s2[a][PROD_W-1:FRAC_W]});
			ip_s3[a] <= sat_pos(p_w - ti_w);
			op_s3[a] <= sat_pos(p_w + to_w);
		end
	end

	// Stage 4: per-axis min and max accumulate
	logic signed [POS_W-1:0] lo_q [3];
	logic signed [POS_W-1:0] hi_q [3];

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [POS_W-1:0] pt_lo, pt_hi;
				pt_lo = (ip_s3[a] < op_s3[a]) ? ip_s3[a] : op_s3[a];
				pt_hi = (ip_s3[a] < op_s3[a]) ? op_s3[a] : ip_s3[a];
				if (first_s3 || (pt_lo < lo_q[a])) begin
					lo_q[a] <= pt_lo;
				end
				if (first_s3 || (pt_hi > hi_q[a])) begin
					hi_q[a] <= pt_hi;
				end
			end
		end
	end

	// Result register; a new result may load as the old one transfers
	logic                    out_valid_q;
	logic signed [POS_W-1:0] min_q [3];
	logic signed [POS_W-1:0] max_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			min_q <= lo_q;
			max_q <= hi_q;
		end
	end

	assign status.last_s3  = vld_s3 && last_s3;
	assign status.out_full = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign min_x     = min_q[0];
	assign min_y     = min_q[1];
	assign min_z     = min_q[2];
	assign max_x     = max_q[0];
	assign max_y     = max_q[1];
	assign max_z     = max_q[2];

endmodule

// ===== design/etbb_checker.sv =====
module etbb_checker
	import etbb_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    cmd,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [POS_W-1:0] min_x,
	input logic signed [POS_W-1:0] min_y,
	input logic signed [POS_W-1:0] min_z,
	input logic signed [POS_W-1:0] max_x,
	input logic signed [POS_W-1:0] max_y,
	input logic signed [POS_W-1:0] max_z
);

	// Stalled result holds: out_valid, min_x and max_z stay stable
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_x) && $stable(max_z))
		else $error("stalled result changed");

	// A query transfer blocks the input in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_QUERY) |=> in_stall)
		else $error("input taken right after a query");

	// A new result only appears at the end of a query, while the input is stalled
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a query in progress");

	// Box is ordered on every axis
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))
		else $error("box minimum above maximum");

endmodule

bind extruded_triangle_bounding_box_core etbb_checker u_chk (.*);
